### design/alist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alist_pkg: shared types and constants of the array list engine
// Word formats of both channels, opcodes, status codes, sequencer states
// and the request bundle that the sequencer drives into the entry memory.
// ----------------------------------------------------------------------------
package alist_pkg;

  // List capacity and data word size.
  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int COUNT_W    = $clog2(DEPTH + 1);

  // Field widths of the two channels.
  localparam int OPCODE_W = 3;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 3;
  localparam int FOUND_W  = 6;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_INSERT     = 3'd4,
    OP_ERASE      = 3'd5,
    OP_FIND       = 3'd6
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_BADPOS    = 3'd3,
    STAT_NOTFOUND  = 3'd4
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE,
    ST_PUT,
    ST_FIND,
    ST_DONE
  } seq_state_t;

  // What the sequencer does with an accepted word.
  typedef enum logic [2:0] {
    PLAN_NONE,
    PLAN_DIRECT,
    PLAN_DEC,
    PLAN_MOVE_INS,
    PLAN_MOVE_ERA,
    PLAN_FIND
  } plan_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]   opcode;
    logic [POS_W-1:0]      position;
    logic signed [DATA_WIDTH-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FOUND_W-1:0]  found_index;
    logic [COUNT_W-1:0]  entry_count;
  } out_word_t;

  // Access request to the entry memory.
  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [ADDR_W-1:0]     raddr;
  } mem_req_t;

endpackage

### design/alist_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alist_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module alist_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/alist_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alist_seq: list operation sequencer
// Decodes each accepted word, keeps the entry count and walks the entry
// memory one entry per cycle to shift entries or search for a value.
// ----------------------------------------------------------------------------
module alist_seq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  alist_pkg::in_word_t                 in_data,
  output logic                                res_valid,
  input  logic                                res_take,
  output alist_pkg::out_word_t                res_data,
  output alist_pkg::mem_req_t                 mem_req,
  input  logic [alist_pkg::DATA_WIDTH-1:0]    mem_rdata
);

  import alist_pkg::*;

  seq_state_t state, state_next;

  logic [COUNT_W-1:0]    count;
  logic [COUNT_W-1:0]    cnt_m1;
  logic                  pend;
  logic                  more;
  logic                  is_ins;
  logic [ADDR_W-1:0]     src;
  logic [ADDR_W-1:0]     last;
  logic [ADDR_W-1:0]     dst;
  logic [ADDR_W-1:0]     pos_r;
  logic [DATA_WIDTH-1:0] value_r;
  status_t               status_r;
  logic [FOUND_W-1:0]    found_r;

  opcode_t               op;
  logic [POS_W-1:0]      ins_pos;
  logic [POS_W-1:0]      era_pos;
  plan_t                 plan;
  status_t               plan_status;
  logic                  hit;

  assign cnt_m1 = count - COUNT_W'(1);
  assign hit    = pend && (mem_rdata == value_r);

  // Decode the word at the input against the current count.
  always_comb begin
    op          = opcode_t'(in_data.opcode);
    ins_pos     = in_data.position;
    era_pos     = in_data.position;
    plan        = PLAN_NONE;
    plan_status = STAT_OK;
    if (op == OP_PUSH_BACK) begin
      ins_pos = count;
    end else if (op == OP_PUSH_FRONT) begin
      ins_pos = '0;
    end
    if (op == OP_POP_FRONT) begin
      era_pos = '0;
    end
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
        if (ins_pos > count) begin
          plan_status = STAT_BADPOS;
        end else if (count == COUNT_W'(DEPTH)) begin
          plan_status = STAT_FULL;
        end else if (ins_pos == count) begin
          plan = PLAN_DIRECT;
        end else begin
          plan = PLAN_MOVE_INS;
        end
      end
      OP_POP_BACK: begin
        if (count == '0) begin
          plan_status = STAT_EMPTY;
        end else begin
          plan = PLAN_DEC;
        end
      end
      OP_POP_FRONT, OP_ERASE: begin
        if (count == '0) begin
          plan_status = STAT_EMPTY;
        end else if (era_pos >= count) begin
          plan_status = STAT_BADPOS;
        end else if (era_pos == cnt_m1) begin
          plan = PLAN_DEC;
        end else begin
          plan = PLAN_MOVE_ERA;
        end
      end
      OP_FIND: begin
        plan_status = STAT_NOTFOUND;
        if (count != '0) begin
          plan = PLAN_FIND;
        end
      end
      default: begin
        plan = PLAN_NONE;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (plan)
            PLAN_MOVE_INS, PLAN_MOVE_ERA: state_next = ST_MOVE;
            PLAN_FIND:                    state_next = ST_FIND;
            default:                      state_next = ST_DONE;
          endcase
        end
      end
      ST_MOVE: begin
        if (!more) begin
          state_next = is_ins ? ST_PUT : ST_DONE;
        end
      end
      ST_PUT: begin
        state_next = ST_DONE;
      end
      ST_FIND: begin
        if (hit || !more) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs: handshake and memory requests.
  always_comb begin
    in_stall      = 1'b1;
    res_valid     = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = dst;
    mem_req.wdata = mem_rdata;
    mem_req.re    = 1'b0;
    mem_req.raddr = src;
    case (state)
      ST_IDLE: begin
        in_stall      = 1'b0;
        mem_req.we    = in_valid && (plan == PLAN_DIRECT);
        mem_req.waddr = count[ADDR_W-1:0];
        mem_req.wdata = in_data.value;
      end
      ST_MOVE: begin
        mem_req.we = pend;
        mem_req.re = more;
      end
      ST_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r;
        mem_req.wdata = value_r;
      end
      ST_FIND: begin
        mem_req.re = more && !hit;
      end
      ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign res_data.status      = status_r;
  assign res_data.found_index = found_r;
  assign res_data.entry_count = count;

  // Count, walk pointers and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      pend  <= 1'b0;
      more  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            is_ins   <= (plan == PLAN_MOVE_INS);
            value_r  <= in_data.value;
            pos_r    <= ins_pos[ADDR_W-1:0];
            status_r <= plan_status;
            found_r  <= '0;
            pend     <= 1'b0;
            more     <= 1'b1;
            case (plan)
              PLAN_DIRECT: begin
                count <= count + COUNT_W'(1);
              end
              PLAN_DEC: begin
                count <= cnt_m1;
              end
              PLAN_MOVE_INS: begin
                src  <= cnt_m1[ADDR_W-1:0];
                last <= ins_pos[ADDR_W-1:0];
              end
              PLAN_MOVE_ERA: begin
                src  <= era_pos[ADDR_W-1:0] + ADDR_W'(1);
                last <= cnt_m1[ADDR_W-1:0];
              end
              PLAN_FIND: begin
                src  <= '0;
                last <= cnt_m1[ADDR_W-1:0];
              end
              default: begin
                more <= 1'b0;
              end
            endcase
          end
        end
        ST_MOVE: begin
          // Read one entry ahead and write the previous one to its new place.
          if (more) begin
            pend <= 1'b1;
            more <= (src != last);
            if (is_ins) begin
              dst <= src + ADDR_W'(1);
              src <= src - ADDR_W'(1);
            end else begin
              dst <= src - ADDR_W'(1);
              src <= src + ADDR_W'(1);
            end
          end else begin
            pend <= 1'b0;
            if (!is_ins) begin
              count <= cnt_m1;
            end
          end
        end
        ST_PUT: begin
          count <= count + COUNT_W'(1);
        end
        ST_FIND: begin
          // Compare the entry read last cycle while reading the next one.
          if (hit) begin
            status_r <= STAT_OK;
            found_r  <= FOUND_W'(dst);
            pend     <= 1'b0;
          end else if (more) begin
            pend <= 1'b1;
            dst  <= src;
            src  <= src + ADDR_W'(1);
            more <= (src != last);
          end else begin
            pend <= 1'b0;
          end
        end
        default: begin
          pend <= 1'b0;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // The count never exceeds the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(DEPTH))
    else $error("entry count above capacity");

  // A shift step never reads and writes the same entry.
  a_move_distinct: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOVE && mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("shift reads and writes one entry");

  // A finished result stays until it is taken.
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !res_take) |=> (state == ST_DONE && $stable(res_data)))
    else $error("result dropped before it was taken");

  // A nonzero found index only comes with a successful status.
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.found_index != '0) |-> (res_data.status == STAT_OK))
    else $error("found index without success");
`endif

endmodule

### design/array_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_engine: ordered list of signed words kept in a RAM
// Push, pop, insert, erase and find on a list of up to 64 entries.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries one word per
//   operation: opcode, position and value. The output channel (out_valid,
//   out_stall, out_data) returns one word per operation: status, found index
//   and the entry count after the operation.
//   One operation is worked at a time. Push back, pop back, any failed
//   operation and an insert or erase at the last place need no walk over
//   the entries. An insert or erase walks over the entries that it moves,
//   an insert then writes the new word, and a find walks until it hits or
//   reaches the end of the list. Each walk goes over the entry RAM one
//   entry per cycle through its single read port.
//   The result sits in an output register; a new word is taken while it
//   waits. When the receiver stalls with a result still held, the next
//   finished result waits in the sequencer and no further word is taken.
//   Reset empties the list and clears both valid flags.
// ----------------------------------------------------------------------------
module array_list_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  alist_pkg::in_word_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output alist_pkg::out_word_t  out_data
);

  import alist_pkg::*;

  mem_req_t              mem_req;
  logic [DATA_WIDTH-1:0] mem_rdata;
  logic                  res_valid;
  logic                  res_take;
  out_word_t             res_data;

  alist_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_data  (res_data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  alist_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // The output register loads when it is empty or being drained.
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res_data;
    end
  end

endmodule

### tb/sv/alist_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alist_checker: result predictor and scoreboard for the array list engine
// Watches both channels, keeps its own copy of the list, predicts the result
// word for every accepted operation and compares each delivered result
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module alist_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  alist_pkg::in_word_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  alist_pkg::out_word_t out_data,
  output int                   fail_count,
  output int                   pending
);

  import alist_pkg::*;

  // Shadow copy of the list contents and its length.
  logic [DATA_WIDTH-1:0] shadow_list [DEPTH];
  int unsigned           shadow_len;

  // Predicted result words, oldest first.
  out_word_t owed_results [$];

  // Insert a word at a place, shifting later entries up by one.
  function automatic status_t list_insert(input int unsigned pos,
                                          input logic [DATA_WIDTH-1:0] word);
    int unsigned i;
    if (pos > shadow_len) return STAT_BADPOS;
    if (shadow_len >= DEPTH) return STAT_FULL;
    for (i = shadow_len; i > pos; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[pos] = word;
    shadow_len++;
    return STAT_OK;
  endfunction

  // Remove the entry at a place, shifting later entries down by one.
  function automatic status_t list_erase(input int unsigned pos);
    int unsigned i;
    if (shadow_len == 0) return STAT_EMPTY;
    if (pos >= shadow_len) return STAT_BADPOS;
    for (i = pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
    shadow_len--;
    return STAT_OK;
  endfunction

  // Apply one operation to the shadow list and return the result it gives.
  function automatic out_word_t list_apply(input in_word_t op_word);
    out_word_t             res;
    status_t               st;
    int unsigned           hit;
    int unsigned           i;
    logic [DATA_WIDTH-1:0] word;
    st   = STAT_OK;
    hit  = 0;
    word = op_word.value;
    case (op_word.opcode)
      OP_PUSH_BACK:  st = list_insert(shadow_len, word);
      OP_PUSH_FRONT: st = list_insert(0, word);
      OP_POP_BACK: begin
        if (shadow_len == 0) st = STAT_EMPTY;
        else shadow_len--;
      end
      OP_POP_FRONT:  st = list_erase(0);
      OP_INSERT:     st = list_insert(op_word.position, word);
      OP_ERASE:      st = list_erase(op_word.position);
      OP_FIND: begin
        st = STAT_NOTFOUND;
        for (i = 0; i < shadow_len; i++) begin
          if (st == STAT_NOTFOUND && shadow_list[i] == word) begin
            st  = STAT_OK;
            hit = i;
          end
        end
      end
      default: ;
    endcase
    res.status      = st;
    res.found_index = hit[FOUND_W-1:0];
    res.entry_count = shadow_len[COUNT_W-1:0];
    return res;
  endfunction

  // Predict on every accepted operation word, check every accepted result.
  always @(posedge clk) begin
    out_word_t due;
    if (rst) begin
      shadow_len = 0;
      owed_results.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $error("result word with no prediction waiting: status %0d count %0d",
                 out_data.status, out_data.entry_count);
          fail_count++;
        end else begin
          due = owed_results.pop_front();
          if (out_data.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, out_data.status);
            fail_count++;
          end
          if (out_data.found_index !== due.found_index) begin
            $error("found_index: expected %0d, got %0d",
                   due.found_index, out_data.found_index);
            fail_count++;
          end
          if (out_data.entry_count !== due.entry_count) begin
            $error("entry_count: expected %0d, got %0d",
                   due.entry_count, out_data.entry_count);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) owed_results.push_back(list_apply(in_data));
      pending <= owed_results.size();
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top level testbench of the array list engine
// Drives a directed set of list operations and then phases of random ones
// that fill, drain and churn the list, with random idling on both sides,
// one long receiver hold-off and one full drain pause. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import alist_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

  localparam int RANDOM_ITEMS = 1030;
  localparam int PHASE_LEN    = 60;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int CALM_FROM    = 600;
  localparam int CALM_TO      = 800;
  localparam int IDLE_PCT     = 6;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 100;

  // Phase kinds of the random part.
  localparam int MODE_FILL  = 0;
  localparam int MODE_MIXED = 1;
  localparam int MODE_DRAIN = 2;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  int          fail_count;
  int          pending;
  int unsigned sent_count = 0;
  int unsigned quiet_cycles = 0;
  logic        calm;

  // No random idling on either side inside this stretch of words.
  assign calm = (sent_count >= CALM_FROM) && (sent_count < CALM_TO);

  always #6 clk = ~clk;

  array_list_engine dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  alist_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic in_word_t make_op(input logic [OPCODE_W-1:0] op,
                                       input int unsigned pos,
                                       input logic [DATA_WIDTH-1:0] val);
    in_word_t w;
    w.opcode   = op;
    w.position = pos[POS_W-1:0];
    w.value    = val;
    return w;
  endfunction

  // Random operation word, biased toward growing or shrinking the list in the fill and drain modes.
  function automatic in_word_t random_op(input int mode);
    logic [OPCODE_W-1:0]   op;
    logic [DATA_WIDTH-1:0] val;
    int unsigned           pos;
    int unsigned           r;
    r = $urandom_range(0, 99);
    if (mode == MODE_FILL) begin
      if (r < 30)      op = OP_PUSH_BACK;
      else if (r < 50) op = OP_PUSH_FRONT;
      else if (r < 75) op = OP_INSERT;
      else if (r < 82) op = OP_POP_BACK;
      else if (r < 88) op = OP_ERASE;
      else if (r < 95) op = OP_FIND;
      else             op = OPCODE_W'($urandom_range(OP_PUSH_BACK, OP_UNUSED));
    end else if (mode == MODE_DRAIN) begin
      if (r < 25)      op = OP_POP_BACK;
      else if (r < 45) op = OP_POP_FRONT;
      else if (r < 70) op = OP_ERASE;
      else if (r < 78) op = OP_PUSH_BACK;
      else if (r < 85) op = OP_INSERT;
      else if (r < 95) op = OP_FIND;
      else             op = OPCODE_W'($urandom_range(OP_PUSH_BACK, OP_UNUSED));
    end else begin
      if (r < 96) op = OPCODE_W'($urandom_range(OP_PUSH_BACK, OP_FIND));
      else        op = OP_UNUSED;
    end
    // A small pool of values makes finds hit and gives duplicates.
    r = $urandom_range(0, 99);
    if (r < 45)      val = $urandom_range(0, 5);
    else if (r < 50) val = -1;
    else             val = $urandom;
    // Mostly small places, which are valid at most list lengths.
    r = $urandom_range(0, 99);
    if (r < 50)      pos = $urandom_range(0, 8);
    else if (r < 80) pos = $urandom_range(0, DEPTH);
    else             pos = $urandom_range(0, (1 << POS_W) - 1);
    return make_op(op, pos, val);
  endfunction

  // Offer one word, with an occasional idle gap first, until it is taken.
  task automatic send_word(input in_word_t w);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  // Drop valid and wait until every predicted result has been delivered.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Sender.
  initial begin
    int mode;
    int k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty list, both ends, extremes, bad places, unused code.
    send_word(make_op(OP_POP_BACK,  0, 0));
    send_word(make_op(OP_POP_FRONT, 0, 0));
    send_word(make_op(OP_ERASE,     0, 0));
    send_word(make_op(OP_FIND,      0, 5));
    send_word(make_op(OP_INSERT,    1, 7));
    send_word(make_op(OP_INSERT,    (1 << POS_W) - 1, 7));
    send_word(make_op(OP_INSERT,    0, 32'h8000_0000));
    send_word(make_op(OP_PUSH_BACK, (1 << POS_W) - 1, 32'h7FFF_FFFF));
    send_word(make_op(OP_PUSH_FRONT, 0, -1));
    send_word(make_op(OP_PUSH_BACK, 0, 0));
    send_word(make_op(OP_INSERT,    4, 5));
    send_word(make_op(OP_INSERT,    2, 5));
    send_word(make_op(OP_FIND,      0, 5));
    send_word(make_op(OP_FIND,      0, -1));
    send_word(make_op(OP_FIND,      0, 12345));
    send_word(make_op(OP_ERASE,     6, 0));
    send_word(make_op(OP_ERASE,     (1 << POS_W) - 1, 0));
    send_word(make_op(OP_ERASE,     2, 0));
    send_word(make_op(OP_ERASE,     4, 0));
    send_word(make_op(OP_UNUSED,    (1 << POS_W) - 1, -1));
    send_word(make_op(OP_POP_FRONT, 0, 0));
    send_word(make_op(OP_POP_BACK,  0, 0));
    send_word(make_op(OP_FIND,      0, 32'h7FFF_FFFF));

    // Let everything come back before the random part starts.
    wait_drained();

    // Random part: fill twice, churn, drain twice, churn, and again.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      case ((k / PHASE_LEN) % 6)
        0, 1:    mode = MODE_FILL;
        3, 4:    mode = MODE_DRAIN;
        default: mode = MODE_MIXED;
      endcase
      send_word(random_op(mode));
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sent_count >= HOLD_AT) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Watchdog: too long without any word moving on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
